@@ hw/rtl/cbt_pkg.sv @@
// shared constants, types and state codes of the cubic b-spline tessellator
package cbt_pkg;

   // field widths and limits
   localparam int COORD_W   = 16;
   localparam int LOD_W     = 7;
   localparam int LOD_RESET = 20;
   localparam int MAX_LOD   = 64;
   localparam int IDX_W     = 6;
   localparam int N_W       = $clog2(MAX_LOD + 1);
   localparam int J_W       = $clog2(MAX_LOD);

   // fixed point layout of t and the weights
   localparam int FRAC_W   = 16;
   localparam int ONE_Q16  = 2 ** FRAC_W;
   localparam int Q_W      = FRAC_W + 1;

   // shared multiplier and accumulator
   localparam int MUL_W    = 20;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int W_W      = 18;
   localparam int X_W      = 19;
   localparam int N1_W     = 21;

   // divide by six as a multiply by a rounded-up reciprocal
   localparam int RECIP_SH = 21;
   localparam int RECIP6   = (2 ** RECIP_SH + 5) / 6;

   // blend: four terms for each of three coordinates
   localparam int TERMS       = 4;
   localparam int BLEND_STEPS = 3 * TERMS;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_SQ,
      S_SQ_W,
      S_CUBE,
      S_CUBE_W,
      S_NUM,
      S_W1,
      S_W2,
      S_W4,
      S_W4_W,
      S_BLEND,
      S_PUSH
   } eng_state_type;

   // divider status towards the sequencer
   typedef struct packed {
      logic             busy;
      logic [Q_W-1:0]   quo;
      logic [N_W-1:0]   rem;
   } div_res_type;

   // curve point offered by the engine
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [IDX_W-1:0] idx;
      coord_type        x;
      coord_type        y;
      coord_type        z;
   } eng_res_type;

endpackage

@@ hw/rtl/cbt_req_if.sv @@
// control point channel: valid, ready and one control point beat
interface cbt_req_if;
   import cbt_pkg::*;

   logic      valid;
   logic      ready;
   logic      first_of_curve;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;

   modport source (
      output valid, first_of_curve, point_x, point_y, point_z,
      input  ready
   );

   modport sink (
      input  valid, first_of_curve, point_x, point_y, point_z,
      output ready
   );

endinterface

@@ hw/rtl/cbt_rsp_if.sv @@
// curve point channel: valid, ready and one curve point beat
interface cbt_rsp_if;
   import cbt_pkg::*;

   logic             valid;
   logic             ready;
   coord_type        curve_x;
   coord_type        curve_y;
   coord_type        curve_z;
   logic [IDX_W-1:0] sample_index;
   logic             segment_end;

   modport source (
      output valid, curve_x, curve_y, curve_z, sample_index, segment_end,
      input  ready
   );

   modport sink (
      input  valid, curve_x, curve_y, curve_z, sample_index, segment_end,
      output ready
   );

endinterface

@@ hw/rtl/cbt_mul.sv @@
// shared signed multiplier with a registered product
module cbt_mul (
   input  logic                              clock,
   input  logic signed [cbt_pkg::MUL_W-1:0]  mul_a,
   input  logic signed [cbt_pkg::MUL_W-1:0]  mul_b,
   output logic signed [cbt_pkg::PROD_W-1:0] prod
);
   import cbt_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // one product per cycle, available the cycle after issue
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hw/rtl/cbt_div.sv @@
// restoring divider: 2^16 divided by the segment point count, one bit a cycle
module cbt_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cbt_pkg::N_W-1:0]   divisor,
   output cbt_pkg::div_res_type      res
);
   import cbt_pkg::*;

   localparam int CNT_W = $clog2(Q_W);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [N_W-1:0]   d_ff;
   logic [N_W-1:0]   rem_ff;
   logic [N_W-1:0]   rem_in;
   logic [Q_W-1:0]   quo_ff;
   logic [Q_W-1:0]   quo_in;
   logic             bit_in;
   logic [N_W:0]     shifted;
   logic             ge;

   // dividend is a single one in its top bit
   assign bit_in  = (cnt_ff == '0);
   assign shifted = {rem_ff, bit_in};
   assign ge      = (shifted >= {1'b0, d_ff});
   assign rem_in  = ge ? N_W'(shifted - {1'b0, d_ff}) : N_W'(shifted);
   assign quo_in  = {quo_ff[Q_W-2:0], ge};

   // step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // quotient and remainder
   always_ff @(posedge clock) begin
      if (start) begin
         d_ff   <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign res.busy = busy_ff;
   assign res.quo  = quo_ff;
   assign res.rem  = rem_ff;

endmodule

@@ hw/rtl/cbt_eng.sv @@
// segment engine: sequencer, weight and blend datapath around the shared multiplier
module cbt_eng (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [cbt_pkg::N_W-1:0]              lod_n,
   input  cbt_pkg::point_type [cbt_pkg::TERMS-1:0] pts,
   input  logic                                 take,
   output cbt_pkg::eng_res_type                 res,
   output logic                                 idle
);
   import cbt_pkg::*;

   localparam int STEP_W = $clog2(BLEND_STEPS + 1);
   localparam logic signed [PROD_W-1:0] HALF_P  = PROD_W'(2 ** (FRAC_W - 1));
   localparam logic signed [PROD_W-1:0] C_MAX   = PROD_W'(2 ** (COORD_W - 1) - 1);
   localparam logic signed [PROD_W-1:0] C_MIN   = ~C_MAX;
   localparam logic signed [N1_W-1:0]   ONE_N   = N1_W'(ONE_Q16);
   localparam logic signed [N1_W-1:0]   FOUR_N  = N1_W'(4 * ONE_Q16);
   localparam logic signed [W_W-1:0]    ONE_W   = W_W'(ONE_Q16);
   localparam logic signed [MUL_W-1:0]  RECIP_M = MUL_W'(RECIP6);
   localparam logic [X_W-1:0]           BIAS6   = X_W'(3);

   eng_state_type state_ff, state_in;

   logic [N_W-1:0]           n_ff;
   logic [J_W-1:0]           j_ff;
   logic [FRAC_W-1:0]        t_ff;
   logic [N_W-1:0]           r_ff;
   logic [FRAC_W-1:0]        t2_ff;
   logic [FRAC_W-1:0]        t3_ff;
   logic [X_W-1:0]           x1_ff, x2_ff, x4_ff;
   logic signed [W_W-1:0]    b_ff [TERMS];
   logic [STEP_W-1:0]        step_ff;
   logic signed [PROD_W-1:0] acc_ff;
   coord_type                res_ff [3];

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic                     div_start;
   div_res_type              div_res;
   logic                     res_valid;

   logic signed [PROD_W-1:0] rnd_sum;
   logic [FRAC_W-1:0]        t_rnd;
   logic signed [W_W-1:0]    w_q;
   logic signed [W_W-1:0]    b3;
   logic signed [N1_W-1:0]   t_e, t2_e, t3_e, n1, n2;
   logic [X_W-1:0]           x1_in, x2_in, x4_in;
   logic [STEP_W-1:0]        prev;
   logic [1:0]               prev_term;
   logic [1:0]               prev_k;
   logic signed [PROD_W-1:0] acc_base, sum, shv;
   coord_type                sat;
   logic [N_W:0]             r_sum;
   logic                     carry;
   logic [N_W-1:0]           r_next;
   logic [FRAC_W-1:0]        t_next;
   logic                     last;

   function automatic coord_type pick(point_type p, logic [1:0] k);
      coord_type c;
      case (k)
         2'd0:    c = p.x;
         2'd1:    c = p.y;
         default: c = p.z;
      endcase
      return c;
   endfunction

   cbt_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   cbt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (lod_n),
      .res     (div_res)
   );

   // rounded q0.16 from a product of two q0.16 values
   assign rnd_sum = prod + HALF_P;
   assign t_rnd   = rnd_sum[FRAC_W +: FRAC_W];

   // weight out of the reciprocal multiply
   assign w_q = signed'(prod[RECIP_SH +: W_W]);
   assign b3  = ONE_W - b_ff[0] - b_ff[1] - w_q;

   // basis numerators
   assign t_e  = signed'(N1_W'(t_ff));
   assign t2_e = signed'(N1_W'(t2_ff));
   assign t3_e = signed'(N1_W'(t3_ff));
   assign n1   = ONE_N - ((t_e <<< 1) + t_e) + ((t2_e <<< 1) + t2_e) - t3_e;
   assign n2   = FOUR_N - ((t2_e <<< 2) + (t2_e <<< 1)) + ((t3_e <<< 1) + t3_e);
   assign x1_in = n1[N1_W-1] ? BIAS6 : X_W'(n1) + BIAS6;
   assign x2_in = n2[N1_W-1] ? BIAS6 : X_W'(n2) + BIAS6;
   assign x4_in = X_W'(t3_ff) + BIAS6;

   // blend accumulate, product of the previous step
   assign prev      = step_ff - STEP_W'(1);
   assign prev_term = prev[1:0];
   assign prev_k    = prev[3:2];
   assign acc_base  = (prev_term == 2'd0) ? HALF_P : acc_ff;
   assign sum       = acc_base + prod;
   assign shv       = sum >>> FRAC_W;
   assign sat       = (shv > C_MAX) ? COORD_W'(C_MAX) :
                      (shv < C_MIN) ? COORD_W'(C_MIN) : COORD_W'(shv);

   // next t by quotient and remainder steps
   assign r_sum  = {1'b0, r_ff} + {1'b0, div_res.rem};
   assign carry  = (r_sum >= {1'b0, n_ff});
   assign r_next = carry ? N_W'(r_sum - {1'b0, n_ff}) : N_W'(r_sum);
   assign t_next = t_ff + div_res.quo[FRAC_W-1:0] + FRAC_W'(carry);

   assign last = (N_W'(j_ff) == n_ff - N_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (start) state_in = S_DIV;
         S_DIV:    if (!div_res.busy) state_in = S_SQ;
         S_SQ:     state_in = S_SQ_W;
         S_SQ_W:   state_in = S_CUBE;
         S_CUBE:   state_in = S_CUBE_W;
         S_CUBE_W: state_in = S_NUM;
         S_NUM:    state_in = S_W1;
         S_W1:     state_in = S_W2;
         S_W2:     state_in = S_W4;
         S_W4:     state_in = S_W4_W;
         S_W4_W:   state_in = S_BLEND;
         S_BLEND:  if (step_ff == STEP_W'(BLEND_STEPS)) state_in = S_PUSH;
         S_PUSH: begin
            if (take) begin
               state_in = last ? S_IDLE : S_SQ;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // multiplier operands and strobes
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         S_IDLE: div_start = start;
         S_SQ: begin
            mul_a = signed'(MUL_W'(t_ff));
            mul_b = signed'(MUL_W'(t_ff));
         end
         S_CUBE: begin
            mul_a = signed'(MUL_W'(t2_ff));
            mul_b = signed'(MUL_W'(t_ff));
         end
         S_W1: begin
            mul_a = signed'(MUL_W'(x1_ff));
            mul_b = RECIP_M;
         end
         S_W2: begin
            mul_a = signed'(MUL_W'(x2_ff));
            mul_b = RECIP_M;
         end
         S_W4: begin
            mul_a = signed'(MUL_W'(x4_ff));
            mul_b = RECIP_M;
         end
         S_BLEND: begin
            if (step_ff < STEP_W'(BLEND_STEPS)) begin
               mul_a = MUL_W'(b_ff[step_ff[1:0]]);
               mul_b = MUL_W'(pick(pts[step_ff[1:0]], step_ff[3:2]));
            end
         end
         S_PUSH: res_valid = 1'b1;
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_ff <= lod_n;
               j_ff <= '0;
               t_ff <= '0;
               r_ff <= '0;
            end
         end
         S_SQ_W:   t2_ff <= t_rnd;
         S_CUBE_W: t3_ff <= t_rnd;
         S_NUM: begin
            x1_ff <= x1_in;
            x2_ff <= x2_in;
            x4_ff <= x4_in;
         end
         S_W2: b_ff[0] <= w_q;
         S_W4: b_ff[1] <= w_q;
         S_W4_W: begin
            b_ff[3] <= w_q;
            b_ff[2] <= b3;
            step_ff <= '0;
         end
         S_BLEND: begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff != '0) begin
               acc_ff <= sum;
               if (prev_term == 2'd3) begin
                  res_ff[prev_k] <= sat;
               end
            end
         end
         S_PUSH: begin
            if (take && !last) begin
               j_ff <= j_ff + J_W'(1);
               t_ff <= t_next;
               r_ff <= r_next;
            end
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

   assign res.valid = res_valid;
   assign res.last  = last;
   assign res.idx   = IDX_W'(j_ff);
   assign res.x     = res_ff[0];
   assign res.y     = res_ff[1];
   assign res.z     = res_ff[2];
   assign idle      = (state_ff == S_IDLE);

endmodule

@@ hw/rtl/cubic_bspline_tessellator.sv @@
// uniform cubic b-spline tessellator: control point window, handshakes, lod register
//
// Control points come in on req_ch, one beat each; curve points leave on rsp_ch.
// A beat with first_of_curve set starts a new curve and empties the window.
// The first three points of a curve are stored in the window and give no output.
// Every later point closes a segment and gives lod curve points, with
// sample_index counting 0 to lod-1 and segment_end on the last one.
// csr_wr_en writes lod (0 acts as 1, above 64 acts as 64); write it only while idle.
// A segment first runs the bit-serial divider for the t step, then per curve point
// the one shared multiplier computes t squared, t cubed, three weights and twelve
// blend terms in turn, plus sequencing.
// req_ch.ready is low for the whole segment. Results sit in an output register;
// the next curve point is computed meanwhile, and if rsp_ch.ready stays low the
// engine holds at the finished point until the register frees.
// Reset clears the window count and the output valid and sets lod to 20.
module cubic_bspline_tessellator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [cbt_pkg::LOD_W-1:0]   csr_wr_data,
   cbt_req_if.sink                     req_ch,
   cbt_rsp_if.source                   rsp_ch
);
   import cbt_pkg::*;

   localparam logic [1:0] HELD_FULL = 2'd3;

   logic [LOD_W-1:0]  lod_ff;
   logic [N_W-1:0]    lod_n;
   logic [1:0]        held_ff;
   logic [1:0]        held_eff;
   point_type         win_ff [3];
   point_type         p_ff;
   point_type         p_new;
   logic              accept;
   logic              start;
   logic              eng_idle;
   eng_res_type       eng_res;
   logic              out_free;
   logic              shift_win;

   logic              rsp_valid_ff;
   coord_type         rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic              rsp_end_ff;

   // lod register
   always_ff @(posedge clock) begin
      if (reset) begin
         lod_ff <= LOD_W'(LOD_RESET);
      end else if (csr_wr_en) begin
         lod_ff <= csr_wr_data;
      end
   end

   // points per segment, clamped
   always_comb begin
      if (lod_ff == '0) begin
         lod_n = N_W'(1);
      end else if (int'(lod_ff) > MAX_LOD) begin
         lod_n = N_W'(MAX_LOD);
      end else begin
         lod_n = N_W'(lod_ff);
      end
   end

   // input beat
   assign req_ch.ready = eng_idle;
   assign accept       = req_ch.valid && req_ch.ready;
   assign held_eff     = req_ch.first_of_curve ? 2'd0 : held_ff;
   assign start        = accept && (held_eff == HELD_FULL);
   assign p_new.x      = req_ch.point_x;
   assign p_new.y      = req_ch.point_y;
   assign p_new.z      = req_ch.point_z;

   // window fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (accept) begin
         held_ff <= (held_eff == HELD_FULL) ? HELD_FULL : held_eff + 2'd1;
      end
   end

   // window storage: append while filling, slide after a finished segment
   always_ff @(posedge clock) begin
      if (accept && !start) begin
         for (int e = 0; e < 3; e++) begin
            if (held_eff == 2'(e)) begin
               win_ff[e] <= p_new;
            end
         end
      end else if (shift_win) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= p_ff;
      end
      if (start) begin
         p_ff <= p_new;
      end
   end

   cbt_eng u_eng (
      .clock (clock),
      .reset (reset),
      .start (start),
      .lod_n (lod_n),
      .pts   ({p_ff, win_ff[2], win_ff[1], win_ff[0]}),
      .take  (out_free),
      .res   (eng_res),
      .idle  (eng_idle)
   );

   // output register
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign shift_win = eng_res.valid && out_free && eng_res.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_res.valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_res.valid && out_free) begin
         rsp_x_ff   <= eng_res.x;
         rsp_y_ff   <= eng_res.y;
         rsp_z_ff   <= eng_res.z;
         rsp_idx_ff <= eng_res.idx;
         rsp_end_ff <= eng_res.last;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.curve_x      = rsp_x_ff;
   assign rsp_ch.curve_y      = rsp_y_ff;
   assign rsp_ch.curve_z      = rsp_z_ff;
   assign rsp_ch.sample_index = rsp_idx_ff;
   assign rsp_ch.segment_end  = rsp_end_ff;

endmodule

@@ bench/tb_cubic_bspline_tessellator.sv @@
// self-checking testbench of the cubic b-spline tessellator, with its own curve point predictor
module tb_cubic_bspline_tessellator;
   import cbt_pkg::*;

   // no accepted beat for this many cycles ends the run
   localparam int IDLE_LIMIT = 3000;
   // quiet cycles before a lod write and at the end of the run
   localparam int SETTLE_CYCLES = 40;
   localparam int TAIL_CYCLES   = 60;
   localparam int LOD_PHASES    = 11;

   localparam point_type P_ZERO = '{x: 16'sh0000, y: 16'sh0000, z: 16'sh0000};
   localparam point_type P_MAX  = '{x: 16'sh7fff, y: 16'sh7fff, z: 16'sh7fff};
   localparam point_type P_MIN  = '{x: 16'sh8000, y: 16'sh8000, z: 16'sh8000};
   localparam point_type P_MIX  = '{x: 16'sh0100, y: 16'shffff, z: 16'sh0000};
   localparam point_type P_EDGE_A = '{x: 16'sh7fff, y: 16'sh8000, z: 16'sh5555};
   localparam point_type P_EDGE_B = '{x: 16'sh8000, y: 16'sh7fff, z: 16'shaaaa};

   typedef struct packed {
      coord_type        x;
      coord_type        y;
      coord_type        z;
      logic [IDX_W-1:0] idx;
      logic             last;
   } curve_point_type;

   // one directed control point, with a typed curve value where it is obvious
   typedef struct {
      bit        first;
      point_type p;
      bit        typed;
      point_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [LOD_W-1:0] csr_wr_data = '0;
   logic             sink_ready = 1'b0;
   logic [9:0]       stall_cycle = '0;

   cbt_req_if req_ch ();
   cbt_rsp_if rsp_ch ();

   assign rsp_ch.ready = sink_ready;

   cubic_bspline_tessellator u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // predictor state: lod, held control points and the curve points still owed
   logic [LOD_W-1:0] lod_shadow = LOD_W'(LOD_RESET);
   point_type        ctrl_window [3];
   int unsigned      ctrl_held = 0;
   curve_point_type  pending_points [$];
   curve_point_type  head;
   int               mismatches = 0;
   int               idle_cycles = 0;
   int unsigned      burst_left = 0;
   stim_row_type     directed_steps [19];

   always #5 clock = ~clock;

   function automatic coord_type blend_coord(input longint w0, input longint w1,
                                             input longint w2, input longint w3,
                                             input coord_type a, input coord_type b,
                                             input coord_type c, input coord_type d);
      longint acc;
      longint hi;
      hi = (longint'(1) <<< (COORD_W - 1)) - 1;
      acc = (w0 * a + w1 * b + w2 * c + w3 * d + 32768) >>> 16;
      if (acc > hi) acc = hi;
      else if (acc < -hi - 1) acc = -hi - 1;
      return coord_type'(acc);
   endfunction

   // window update and the curve points of a closed segment
   function automatic void tessellate_point(input bit first, input point_type p,
                                            input bit typed, input point_type want);
      int unsigned     seg_len;
      longint          t, t2, t3, n1, n2, w0, w1, w2, w3;
      curve_point_type cp;
      seg_len = 32'(lod_shadow);
      if (seg_len == 0) seg_len = 1;
      else if (seg_len > MAX_LOD) seg_len = MAX_LOD;
      if (first) ctrl_held = 0;
      if (ctrl_held < 3) begin
         ctrl_window[ctrl_held] = p;
         ctrl_held++;
         return;
      end
      for (int unsigned j = 0; j < seg_len; j++) begin
         // basis weights at t = j / lod in q0.16
         t  = (longint'(j) << 16) / longint'(seg_len);
         t2 = (t * t + 32768) >> 16;
         t3 = (t2 * t + 32768) >> 16;
         n1 = ONE_Q16 - 3 * t + 3 * t2 - t3;
         n2 = 4 * ONE_Q16 - 6 * t2 + 3 * t3;
         if (n1 < 0) n1 = 0;
         if (n2 < 0) n2 = 0;
         w0 = (n1 + 3) / 6;
         w1 = (n2 + 3) / 6;
         w3 = (t3 + 3) / 6;
         w2 = ONE_Q16 - w0 - w1 - w3;
         cp.x = typed ? want.x : blend_coord(w0, w1, w2, w3, ctrl_window[0].x,
                                             ctrl_window[1].x, ctrl_window[2].x, p.x);
         cp.y = typed ? want.y : blend_coord(w0, w1, w2, w3, ctrl_window[0].y,
                                             ctrl_window[1].y, ctrl_window[2].y, p.y);
         cp.z = typed ? want.z : blend_coord(w0, w1, w2, w3, ctrl_window[0].z,
                                             ctrl_window[1].z, ctrl_window[2].z, p.z);
         cp.idx  = IDX_W'(j);
         cp.last = (j == seg_len - 1);
         pending_points.insert(pending_points.size(), cp);
      end
      ctrl_window[0] = ctrl_window[1];
      ctrl_window[1] = ctrl_window[2];
      ctrl_window[2] = p;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2, 3, 4: return coord_type'($urandom_range(0, 1023) - 512);
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // offer one control point beat and hold it until taken
   task automatic send_point(input bit first, input point_type p,
                             input bit typed, input point_type want);
      req_ch.valid          <= 1'b1;
      req_ch.first_of_curve <= first;
      req_ch.point_x        <= p.x;
      req_ch.point_y        <= p.y;
      req_ch.point_z        <= p.z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tessellate_point(first, p, typed, want);
   endtask

   // bursts of random length with random gaps, some bursts run on without a gap
   task automatic pace_sender();
      int unsigned gap;
      gap = 0;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
      end
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      if (pending_points.size() != 0) begin
         req_ch.valid <= 1'b0;
         while (pending_points.size() != 0) @(posedge clock);
      end
   endtask

   task automatic write_lod(input logic [LOD_W-1:0] value);
      drain_results();
      req_ch.valid <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      lod_shadow = value;
   endtask

   // receiver stall pattern, mode chosen by stall_cycle[9:8]
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1'b1;
      case (stall_cycle[9:8])
         2'd0: sink_ready <= 1'b1;
         2'd1: sink_ready <= ($urandom_range(0, 3) != 0);
         2'd2: sink_ready <= ((stall_cycle % 17) >= 11);
         default: sink_ready <= 1'($urandom_range(0, 1));
      endcase
   end

   // curve point checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_points.size() == 0) begin
            report_mismatch("curve point beat with none expected, curve_x",
                            rsp_ch.curve_x, 0);
         end else begin
            head = pending_points.pop_front();
            if (rsp_ch.curve_x !== head.x) report_mismatch("curve_x", rsp_ch.curve_x, head.x);
            if (rsp_ch.curve_y !== head.y) report_mismatch("curve_y", rsp_ch.curve_y, head.y);
            if (rsp_ch.curve_z !== head.z) report_mismatch("curve_z", rsp_ch.curve_z, head.z);
            if (rsp_ch.sample_index !== head.idx)
               report_mismatch("sample_index", rsp_ch.sample_index, head.idx);
            if (rsp_ch.segment_end !== head.last)
               report_mismatch("segment_end", rsp_ch.segment_end, head.last);
         end
      end
   end

   // watchdog on cycles without any accepted beat or register write
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("** cubic_bspline_tessellator: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          lod_plan [LOD_PHASES];
      int unsigned lod_val, eff_lod, items_left, run_len, seg_kind, random_beats;
      bit          first;

      req_ch.valid          <= 1'b0;
      req_ch.first_of_curve <= 1'b0;
      req_ch.point_x        <= '0;
      req_ch.point_y        <= '0;
      req_ch.point_z        <= '0;

      // constant curves give the control value at every step
      directed_steps = '{
         '{1'b1, P_MAX,    1'b0, P_ZERO},
         '{1'b0, P_MAX,    1'b0, P_ZERO},
         '{1'b0, P_MAX,    1'b0, P_ZERO},
         '{1'b0, P_MAX,    1'b1, P_MAX},
         '{1'b1, P_MIN,    1'b0, P_ZERO},
         '{1'b0, P_MIN,    1'b0, P_ZERO},
         // restart with two points held
         '{1'b1, P_MIN,    1'b0, P_ZERO},
         '{1'b0, P_MIN,    1'b0, P_ZERO},
         '{1'b0, P_MIN,    1'b0, P_ZERO},
         '{1'b0, P_MIN,    1'b1, P_MIN},
         // restart with a full window
         '{1'b1, P_MIX,    1'b0, P_ZERO},
         '{1'b0, P_MIX,    1'b0, P_ZERO},
         '{1'b0, P_MIX,    1'b0, P_ZERO},
         '{1'b0, P_MIX,    1'b1, P_MIX},
         // swings between the extremes
         '{1'b0, P_EDGE_A, 1'b0, P_ZERO},
         '{1'b0, P_EDGE_B, 1'b0, P_ZERO},
         '{1'b0, P_ZERO,   1'b0, P_ZERO},
         '{1'b0, P_MAX,    1'b0, P_ZERO},
         '{1'b0, P_MIN,    1'b0, P_ZERO}
      };
      // lod settings: at the floor, zero, the ceiling and above it
      lod_plan = '{1, 0, 64, 5, 127, 2, 33, 3, 65, 20, 0};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset lod
      foreach (directed_steps[i]) begin
         send_point(directed_steps[i].first, directed_steps[i].p,
                    directed_steps[i].typed, directed_steps[i].want);
         pace_sender();
      end

      // random curves, one lod setting per phase
      random_beats = 0;
      for (int phase = 0; phase < LOD_PHASES; phase++) begin
         lod_val = (phase == LOD_PHASES - 1) ? $urandom_range(1, 16) : lod_plan[phase];
         write_lod(LOD_W'(lod_val));
         eff_lod = (lod_val == 0) ? 1 : ((lod_val > MAX_LOD) ? MAX_LOD : lod_val);
         items_left = (eff_lod > 32) ? 6 : 20;
         while (items_left > 0) begin
            seg_kind = $urandom_range(0, 9);
            if (seg_kind == 0) run_len = 1;
            else if (seg_kind == 1) run_len = $urandom_range(1, 2);
            else run_len = $urandom_range(4, 9);
            if (run_len > items_left) run_len = items_left;
            for (int k = 0; k < run_len; k++) begin
               // a stray point carries a random flag, a curve starts with the flag
               first = (seg_kind == 0) ? bit'($urandom_range(0, 1)) : (k == 0);
               if (random_beats == 40 || $urandom_range(0, 29) == 0) drain_results();
               send_point(first, '{x: rand_coord(), y: rand_coord(), z: rand_coord()},
                          1'b0, P_ZERO);
               pace_sender();
               random_beats++;
            end
            items_left = items_left - run_len;
         end
      end

      drain_results();
      req_ch.valid <= 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("** cubic_bspline_tessellator: PASSED **");
      else
         $display("** cubic_bspline_tessellator: FAILED **");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/cbt_pkg.sv
hw/rtl/cbt_req_if.sv
hw/rtl/cbt_rsp_if.sv
hw/rtl/cbt_mul.sv
hw/rtl/cbt_div.sv
hw/rtl/cbt_eng.sv
hw/rtl/cubic_bspline_tessellator.sv
bench/tb_cubic_bspline_tessellator.sv
